>>> rtl/pmi_pkg.sv
// Shared constants and types of the particle motion integrator.
package pmi_pkg;

	// Fixed-point format of position and velocity.
	localparam int FRAC_BITS = 16;
	localparam int WORD_W = 32;
	localparam int PROD_W = 2 * WORD_W;

	// Friction is Q1.16 regardless of the state format.
	localparam int FRIC_W = 17;
	localparam int FRIC_SHIFT = 16;
	localparam logic [FRIC_W-1:0] FRIC_ONE = FRIC_W'(65536);

	// Magnitudes below 0.00001 snap to zero after a push.
	localparam int SNAP_DIV = 100000;
	localparam int SNAP_LIM = ((1 << FRAC_BITS) + SNAP_DIV - 1) / SNAP_DIV;

	// Configuration registers.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd2;
	localparam logic [FRIC_W-1:0] FRICTION_RST = FRIC_W'(6554);
	localparam logic [CFG_DATA_W-1:0] TICK_SPEED_RST = CFG_DATA_W'(65536);
	localparam logic [CFG_DATA_W-1:0] MAX_SPEED_RST = CFG_DATA_W'(655360);

	// Command modes.
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_PUSH = 2'd1;
	localparam logic [1:0] MODE_LOAD_POS = 2'd2;
	localparam logic [1:0] MODE_LOAD_VEL = 2'd3;

	// Iterative unit operation and handshake groups.
	typedef enum logic {
		IU_SQRT,
		IU_DIV
	} iu_op_t;

	typedef struct packed {
		logic start;
		iu_op_t op;
	} iu_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iu_stat_t;

endpackage

>>> rtl/pmi_stream_if.sv
// Command and result channel interfaces of the particle motion integrator.
interface pmi_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;

	modport source (output valid, mode, vec_x, vec_y, input ready);
	modport sink (input valid, mode, vec_x, vec_y, output ready);
endinterface

interface pmi_res_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

>>> rtl/pmi_iter_unit.sv
// Shared bit-serial unit: 64-bit integer square root or 64/32 divide, 32 steps.
module pmi_iter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pmi_pkg::iu_ctrl_t                  ctrl,
	input  logic [pmi_pkg::PROD_W-1:0]         opnd_n,
	input  logic [pmi_pkg::WORD_W-1:0]         opnd_d,
	output pmi_pkg::iu_stat_t                  stat,
	output logic [pmi_pkg::WORD_W-1:0]         result
);

	localparam int W = pmi_pkg::WORD_W;
	localparam int PW = pmi_pkg::PROD_W;
	localparam int CNT_W = $clog2(W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	pmi_pkg::iu_op_t op_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] root_q;
	logic [PW-1:0] bit_q;
	logic [W-1:0] d_q;

	// Square root step: trial subtract of root plus the current bit pair.
	logic [PW-1:0] sq_trial;
	logic sq_ge;
	// Divide step: shift in the next dividend bit and try the divisor.
	logic [W:0] dv_trial;
	logic dv_ge;

	always_comb begin
		sq_trial = root_q + bit_q;
		sq_ge = (rem_q >= sq_trial);
		dv_trial = {rem_q[W-1:0], root_q[W-1]};
		dv_ge = (dv_trial >= {1'b0, d_q});
	end

	// Sequencing and the shared working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= pmi_pkg::IU_SQRT;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= ctrl.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == {CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			if (ctrl.op == pmi_pkg::IU_SQRT) begin
				rem_q <= opnd_n;
				root_q <= '0;
				bit_q <= PW'(1) << (PW - 2);
			end else begin
				rem_q <= {{W{1'b0}}, opnd_n[PW-1:W]};
				root_q <= {{W{1'b0}}, opnd_n[W-1:0]};
				bit_q <= '0;
			end
			d_q <= opnd_d;
		end else if (busy_q) begin
			if (op_q == pmi_pkg::IU_SQRT) begin
				if (sq_ge) begin
					rem_q <= rem_q - sq_trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				if (dv_ge) begin
					rem_q <= {{W{1'b0}}, dv_trial[W-1:0] - d_q};
				end else begin
					rem_q <= {{W{1'b0}}, dv_trial[W-1:0]};
				end
				root_q <= {{W{1'b0}}, root_q[W-2:0], dv_ge};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result = root_q[W-1:0];

endmodule

>>> rtl/particle_motion_integrator_core.sv
// Top level of the particle motion integrator: state, sequencer and shared multiplier.
//
//   port       dir     beat contents
//   cmd        sink    mode, vec_x, vec_y
//   res        source  pos_x, pos_y, vel_x, vel_y
//   cfg_*      write   friction, tick_speed, max_speed
//
// A push with clamping runs one square root of the 64-bit squared magnitude and
// two 64/32 divides in the shared bit-serial unit, 32 steps each.
// The shared 32x32 multiplier is registered and used once per cycle.
// Reset clears position, velocity and loads the register defaults.
// A result waiting on res does not block the next command being taken.
module particle_motion_integrator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	pmi_cmd_if.sink                                cmd,
	pmi_res_if.source                              res,
	input  logic                                   cfg_we,
	input  logic [pmi_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [pmi_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	localparam int W = pmi_pkg::WORD_W;
	localparam int PW = pmi_pkg::PROD_W;
	localparam int FS = pmi_pkg::FRIC_SHIFT;

	typedef enum logic [3:0] {
		S_IDLE,
		S_T_THR,
		S_T_MX,
		S_T_MY,
		S_T_FY,
		S_P_MX,
		S_P_MY,
		S_P_ML,
		S_P_CMP,
		S_SQ_WAIT,
		S_DX_START,
		S_DX_WAIT,
		S_DY_START,
		S_DY_WAIT,
		S_P_SNAP,
		S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic [pmi_pkg::FRIC_W-1:0] fric_q;
	logic [pmi_pkg::CFG_DATA_W-1:0] tick_q;
	logic [pmi_pkg::CFG_DATA_W-1:0] lim_q;
	logic signed [W-1:0] pos_q [2];
	logic signed [W-1:0] vel_q [2];
	logic [W-1:0] thr_q;
	logic [PW-1:0] m2_q;
	logic [W-1:0] m_q;
	logic [PW-1:0] mul_q;
	logic res_valid_q;
	logic signed [W-1:0] res_pos_x_q;
	logic signed [W-1:0] res_pos_y_q;
	logic signed [W-1:0] res_vel_x_q;
	logic signed [W-1:0] res_vel_y_q;

	pmi_pkg::iu_ctrl_t iu_ctrl;
	pmi_pkg::iu_stat_t iu_stat;
	logic [W-1:0] iu_result;
	logic [W-1:0] iu_d;

	logic [W-1:0] mul_a;
	logic [W-1:0] mul_b;
	logic [pmi_pkg::FRIC_W-1:0] fmin;
	logic [W-1:0] mag0;
	logic [W-1:0] mag1;
	logic [W-1:0] fric_rem;
	logic cmd_take;
	logic res_free;

	// Saturating signed 32-bit add.
	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_add = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			sat_add = s[W-1:0];
		end
	endfunction

	// Magnitude as unsigned; the most negative value maps to 2^31.
	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? W'(-v) : W'(v);
	endfunction

	// Reapply a sign to a magnitude.
	function automatic logic signed [W-1:0] signed_of(input logic neg, input logic [W-1:0] a);
		signed_of = neg ? -$signed(a) : $signed(a);
	endfunction

	// Stop threshold compare after friction decay.
	function automatic logic signed [W-1:0] decay(input logic neg, input logic [W-1:0] a,
			input logic [W-1:0] thr);
		decay = (a < thr) ? '0 : signed_of(neg, a);
	endfunction

	always_comb begin
		fmin = (fric_q > pmi_pkg::FRIC_ONE) ? pmi_pkg::FRIC_ONE : fric_q;
		mag0 = mag(vel_q[0]);
		mag1 = mag(vel_q[1]);
		cmd_take = cmd.valid && cmd.ready;
		res_free = !res_valid_q || res.ready;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_T_THR: begin
				mul_a = W'(fmin);
				mul_b = W'(tick_q);
			end
			S_T_MX: begin
				mul_a = mag0;
				mul_b = W'(fmin);
			end
			S_T_MY: begin
				mul_a = mag1;
				mul_b = W'(fmin);
			end
			S_P_MX: begin
				mul_a = mag0;
				mul_b = mag0;
			end
			S_P_MY: begin
				mul_a = mag1;
				mul_b = mag1;
			end
			S_P_ML: begin
				mul_a = W'(lim_q);
				mul_b = W'(lim_q);
			end
			S_P_CMP, S_SQ_WAIT: begin
				mul_a = mag0;
				mul_b = W'(lim_q);
			end
			S_DX_START, S_DX_WAIT: begin
				mul_a = mag1;
				mul_b = W'(lim_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		// Velocity magnitude after friction, from the product of the previous cycle.
		fric_rem = ((state_q == S_T_MY) ? mag0 : mag1) - mul_q[FS+W-1:FS];
	end

	always_ff @(posedge clk) begin
		mul_q <= PW'(mul_a) * PW'(mul_b);
	end

	// Shared root and divide unit.
	always_comb begin
		iu_ctrl.start = (state_q == S_P_CMP && m2_q > mul_q) ||
			state_q == S_DX_START || state_q == S_DY_START;
		iu_ctrl.op = (state_q == S_P_CMP) ? pmi_pkg::IU_SQRT : pmi_pkg::IU_DIV;
		iu_d = m_q;
	end

	pmi_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (iu_ctrl),
		.opnd_n ((state_q == S_P_CMP) ? m2_q : mul_q),
		.opnd_d (iu_d),
		.stat   (iu_stat),
		.result (iu_result)
	);

	// Sequencer, state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= pmi_pkg::MODE_TICK;
			fric_q <= pmi_pkg::FRICTION_RST;
			tick_q <= pmi_pkg::TICK_SPEED_RST;
			lim_q <= pmi_pkg::MAX_SPEED_RST;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			vel_q[0] <= '0;
			vel_q[1] <= '0;
			thr_q <= '0;
			m2_q <= '0;
			m_q <= '0;
			res_valid_q <= 1'b0;
			res_pos_x_q <= '0;
			res_pos_y_q <= '0;
			res_vel_x_q <= '0;
			res_vel_y_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					pmi_pkg::REG_FRICTION: fric_q <= cfg_wdata[pmi_pkg::FRIC_W-1:0];
					pmi_pkg::REG_TICK_SPEED: tick_q <= cfg_wdata;
					pmi_pkg::REG_MAX_SPEED: lim_q <= cfg_wdata;
					default: ;
				endcase
			end
			// The completion state refills the result register itself.
			if (res_valid_q && res.ready && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						mode_q <= cmd.mode;
						unique case (cmd.mode)
							pmi_pkg::MODE_TICK: state_q <= S_T_THR;
							pmi_pkg::MODE_PUSH: begin
								vel_q[0] <= sat_add(vel_q[0], cmd.vec_x);
								vel_q[1] <= sat_add(vel_q[1], cmd.vec_y);
								state_q <= S_P_MX;
							end
							pmi_pkg::MODE_LOAD_POS: begin
								pos_q[0] <= cmd.vec_x;
								pos_q[1] <= cmd.vec_y;
								state_q <= S_DONE;
							end
							default: begin
								vel_q[0] <= cmd.vec_x;
								vel_q[1] <= cmd.vec_y;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_T_THR: begin
					pos_q[0] <= sat_add(pos_q[0], vel_q[0]);
					pos_q[1] <= sat_add(pos_q[1], vel_q[1]);
					state_q <= S_T_MX;
				end
				S_T_MX: begin
					thr_q <= mul_q[FS+W-1:FS];
					state_q <= S_T_MY;
				end
				S_T_MY: begin
					vel_q[0] <= decay(vel_q[0][W-1], fric_rem, thr_q);
					state_q <= S_T_FY;
				end
				S_T_FY: begin
					vel_q[1] <= decay(vel_q[1][W-1], fric_rem, thr_q);
					state_q <= S_DONE;
				end
				S_P_MX: state_q <= S_P_MY;
				S_P_MY: begin
					m2_q <= mul_q;
					state_q <= S_P_ML;
				end
				S_P_ML: begin
					m2_q <= m2_q + mul_q;
					state_q <= S_P_CMP;
				end
				S_P_CMP: begin
					state_q <= (m2_q > mul_q) ? S_SQ_WAIT : S_P_SNAP;
				end
				S_SQ_WAIT: begin
					if (iu_stat.done) begin
						m_q <= (iu_result == '0) ? W'(1) : iu_result;
						state_q <= S_DX_START;
					end
				end
				S_DX_START: state_q <= S_DX_WAIT;
				S_DX_WAIT: begin
					if (iu_stat.done) begin
						vel_q[0] <= signed_of(vel_q[0][W-1], iu_result);
						state_q <= S_DY_START;
					end
				end
				S_DY_START: state_q <= S_DY_WAIT;
				S_DY_WAIT: begin
					if (iu_stat.done) begin
						vel_q[1] <= signed_of(vel_q[1][W-1], iu_result);
						state_q <= S_P_SNAP;
					end
				end
				S_P_SNAP: begin
					if (mag0 < W'(pmi_pkg::SNAP_LIM)) begin
						vel_q[0] <= '0;
					end
					if (mag1 < W'(pmi_pkg::SNAP_LIM)) begin
						vel_q[1] <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						res_pos_x_q <= pos_q[0];
						res_pos_y_q <= pos_q[1];
						res_vel_x_q <= vel_q[0];
						res_vel_y_q <= vel_q[1];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign res.valid = res_valid_q;
	assign res.pos_x = res_pos_x_q;
	assign res.pos_y = res_pos_y_q;
	assign res.vel_x = res_vel_x_q;
	assign res.vel_y = res_vel_y_q;

`ifndef SYNTH
	// A position load lands in the state on the next edge.
	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.mode == pmi_pkg::MODE_LOAD_POS
		|=> pos_q[0] == $past(cmd.vec_x) && pos_q[1] == $past(cmd.vec_y))
		else $error("position load not applied");

	// The shared unit only runs while the sequencer waits on it.
	a_iu_owner: assert property (@(posedge clk) disable iff (!arst_n)
		iu_stat.busy |-> (state_q == S_SQ_WAIT || state_q == S_DX_WAIT ||
			state_q == S_DY_WAIT || state_q == S_DX_START || state_q == S_DY_START))
		else $error("iterative unit busy outside a wait state");

	// A new result beat is only raised from the completion state.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");
`endif

endmodule
